### rtl/core/ber_tlv_stream_parser_assert.svh
// ----------------------------------------------------------------------------
// BER-TLV stream parser assertion macros
// Shared assertion forms clocked on i_clk, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef BER_TLV_STREAM_PARSER_ASSERT_SVH
`define BER_TLV_STREAM_PARSER_ASSERT_SVH

// Checked only while the block is out of reset.
`define BTLV_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BTLV_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/core/btlv_pkg.sv
// ----------------------------------------------------------------------------
// BER-TLV parser package
// Phase, kind and error codes, and the types shared by the parser modules.
// ----------------------------------------------------------------------------
package btlv_pkg;

    localparam int unsigned MAX_LENGTH_BYTES = 4;
    localparam int unsigned LEN_CNT_W        = 3;
    localparam int unsigned S_TDATA_W        = 8;
    localparam int unsigned M_TDATA_W        = 72;

    localparam logic [2:0] PH_TAG1  = 3'd0;
    localparam logic [2:0] PH_TAG2  = 3'd1;
    localparam logic [2:0] PH_TAG3  = 3'd2;
    localparam logic [2:0] PH_LEN1  = 3'd3;
    localparam logic [2:0] PH_LENN  = 3'd4;
    localparam logic [2:0] PH_VALUE = 3'd5;
    localparam logic [2:0] PH_ERROR = 3'd6;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_ZERO_TAG   = 2'd0;
    localparam logic [1:0] ERR_TAG3_CONT  = 2'd1;
    localparam logic [1:0] ERR_LEN_COUNT  = 2'd2;
    localparam logic [1:0] ERR_INDEFINITE = 2'd3;

    typedef struct packed {
        logic [2:0]           phase;
        logic [23:0]          tag_accum;
        logic [1:0]           tag_count;
        logic [1:0]           class_bits;
        logic                 constructed;
        logic [31:0]          length_accum;
        logic [LEN_CNT_W-1:0] len_left;
        logic [31:0]          val_left;
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] tag;
        logic [1:0]  tag_size;
        logic [1:0]  tag_class;
        logic        constructed;
        logic [31:0] value_length;
        logic [7:0]  value_byte;
        logic        last;
        logic [1:0]  error_code;
    } t_item;

endpackage

### rtl/core/btlv_step.sv
// ----------------------------------------------------------------------------
// BER-TLV byte decoder
// Computes the next parser state and the optional result for one byte.
// ----------------------------------------------------------------------------
module btlv_step (
    input  btlv_pkg::t_state i_state,
    input  logic [7:0]       i_byte,
    input  logic             i_start,
    output btlv_pkg::t_state o_next,
    output logic             o_emit,
    output btlv_pkg::t_item  o_item
);
    import btlv_pkg::*;

    logic [2:0]           w_phase;
    logic                 w_hdr;
    logic [31:0]          w_hdr_len;
    logic [6:0]           w_count;
    logic [31:0]          w_len_shift;
    logic [LEN_CNT_W-1:0] w_len_dec;
    logic [31:0]          w_val_dec;

    assign w_count     = i_byte[6:0];
    assign w_len_shift = {i_state.length_accum[23:0], i_byte};
    assign w_len_dec   = i_state.len_left - LEN_CNT_W'(i_state.len_left != '0);
    assign w_val_dec   = i_state.val_left - 32'(i_state.val_left != '0);

    always_comb begin
        o_next    = i_state;
        o_emit    = 1'b0;
        o_item    = '0;
        w_hdr     = 1'b0;
        w_hdr_len = '0;
        w_phase   = i_start ? PH_TAG1 : i_state.phase;
        unique case (w_phase)
            PH_TAG1: begin
                if (i_byte == 8'h00) begin
                    o_emit            = 1'b1;
                    o_item.kind       = KIND_ERROR;
                    o_item.error_code = ERR_ZERO_TAG;
                    o_next.phase      = PH_ERROR;
                end else begin
                    o_next.tag_accum   = {16'h0000, i_byte};
                    o_next.tag_count   = 2'd1;
                    o_next.class_bits  = i_byte[7:6];
                    o_next.constructed = i_byte[5];
                    o_next.phase       = (i_byte[4:0] == 5'h1F) ? PH_TAG2 : PH_LEN1;
                end
            end
            PH_TAG2: begin
                o_next.tag_accum = {i_state.tag_accum[15:0], i_byte};
                o_next.tag_count = 2'd2;
                o_next.phase     = i_byte[7] ? PH_TAG3 : PH_LEN1;
            end
            PH_TAG3: begin
                if (i_byte[7]) begin
                    o_emit            = 1'b1;
                    o_item.kind       = KIND_ERROR;
                    o_item.error_code = ERR_TAG3_CONT;
                    o_next.phase      = PH_ERROR;
                end else begin
                    o_next.tag_accum = {i_state.tag_accum[15:0], i_byte};
                    o_next.tag_count = 2'd3;
                    o_next.phase     = PH_LEN1;
                end
            end
            PH_LEN1: begin
                if (!i_byte[7]) begin
                    w_hdr     = 1'b1;
                    w_hdr_len = {24'h000000, i_byte};
                end else if (w_count == 7'd0) begin
                    o_emit            = 1'b1;
                    o_item.kind       = KIND_ERROR;
                    o_item.error_code = ERR_INDEFINITE;
                    o_next.phase      = PH_ERROR;
                end else if (w_count > 7'(MAX_LENGTH_BYTES)) begin
                    o_emit            = 1'b1;
                    o_item.kind       = KIND_ERROR;
                    o_item.error_code = ERR_LEN_COUNT;
                    o_next.phase      = PH_ERROR;
                end else begin
                    o_next.length_accum = '0;
                    o_next.len_left     = w_count[LEN_CNT_W-1:0];
                    o_next.phase        = PH_LENN;
                end
            end
            PH_LENN: begin
                o_next.length_accum = w_len_shift;
                o_next.len_left     = w_len_dec;
                if (w_len_dec == '0) begin
                    w_hdr     = 1'b1;
                    w_hdr_len = w_len_shift;
                end
            end
            PH_VALUE: begin
                o_emit            = 1'b1;
                o_item.kind       = KIND_VALUE;
                o_item.value_byte = i_byte;
                o_item.last       = (i_state.val_left <= 32'd1);
                o_next.val_left   = w_val_dec;
                if (w_val_dec == '0) begin
                    o_next.phase = PH_TAG1;
                end
            end
            default: begin
                o_next.phase = PH_ERROR;
            end
        endcase

        if (w_hdr) begin
            o_emit              = 1'b1;
            o_item.kind         = KIND_HEADER;
            o_item.tag          = i_state.tag_accum;
            o_item.tag_size     = i_state.tag_count;
            o_item.tag_class    = i_state.class_bits;
            o_item.constructed  = i_state.constructed;
            o_item.value_length = w_hdr_len;
            o_item.last         = (w_hdr_len == '0);
            o_next.length_accum = w_hdr_len;
            if (w_hdr_len == '0) begin
                o_next.phase = PH_TAG1;
            end else begin
                o_next.val_left = w_hdr_len;
                o_next.phase    = PH_VALUE;
            end
        end
    end

endmodule

### rtl/core/ber_tlv_stream_parser.sv
// ----------------------------------------------------------------------------
// BER-TLV stream parser
// Throughput is one word per cycle while the output is not stalled; each
// accepted byte passes from the input register through the byte decoder
// into the result register. A synchronous active-low reset empties both
// registers and returns the parser to expect the first byte of a tag.
// ----------------------------------------------------------------------------
module ber_tlv_stream_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // data_byte [7:0]
    input  logic [btlv_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // start_req [0]
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tag [23:0], tag_size [25:24], tag_class [27:26], constructed [28],
    // value_length [60:29], value_byte [68:61], error_code [70:69], zero [71]
    output logic [btlv_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // kind [1:0]
    output logic [1:0]                       o_m_tuser,
    // last_of_value
    output logic                             o_m_tlast
);
    import btlv_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;
    logic       r_out_valid;
    t_item      r_out;
    t_state     r_state;

    t_state     w_next;
    t_item      w_item;
    logic       w_emit;
    logic       w_fire;
    logic       w_take;

    assign w_fire     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_fire;
    assign w_take     = i_s_tvalid && o_s_tready;

    btlv_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_start (r_in_start),
        .o_next  (w_next),
        .o_emit  (w_emit),
        .o_item  (w_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{phase: PH_TAG1, default: '0};
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= w_emit;
                r_state     <= w_next;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte  <= i_s_tdata;
            r_in_start <= i_s_tuser;
        end
        if (w_fire) begin
            r_out <= w_item;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.last;
    assign o_m_tdata  = {1'b0, r_out.error_code, r_out.value_byte, r_out.value_length,
                         r_out.constructed, r_out.tag_class, r_out.tag_size, r_out.tag};

`include "ber_tlv_stream_parser_assert.svh"

    `BTLV_ASSERT_RUN(a_error_parks, (w_fire && w_emit && w_item.kind == KIND_ERROR) |=> (r_state.phase == PH_ERROR), "error result did not park the parser")
    `BTLV_ASSERT_RUN(a_value_count, (r_state.phase == PH_VALUE) |-> (r_state.val_left != '0), "value phase with no bytes left")
    `BTLV_ASSERT_RUN(a_header_last, (r_out_valid && r_out.kind == KIND_HEADER) |-> (r_out.last == (r_out.value_length == '0)), "header last mark disagrees with length")
    `BTLV_ASSERT_ALL(a_reset_empty, !i_rst_n |=> (!r_in_valid && !r_out_valid), "registers not empty after reset")

endmodule
